FILE: design/lpm_pkg.sv
`timescale 1ns / 1ps
package lpm_pkg;

	localparam int SLOT_W      = 4;
	localparam int ADDR_W      = 32;
	localparam int PORT_W      = 2;
	localparam int IN_TDATA_W  = 136;
	localparam int OUT_TDATA_W = 40;

	typedef enum logic {
		CMD_LOOKUP = 1'b0,
		CMD_WRITE  = 1'b1
	} cmd_t;

	typedef struct packed {
		logic              valid;
		cmd_t              cmd;
		logic [SLOT_W-1:0] slot;
		logic              slot_valid;
		logic [ADDR_W-1:0] prefix;
		logic [ADDR_W-1:0] mask;
		logic [ADDR_W-1:0] gateway;
		logic [PORT_W-1:0] port;
		logic [ADDR_W-1:0] addr;
		logic              hit;
		logic [SLOT_W-1:0] best_slot;
		logic [ADDR_W-1:0] best_mask;
		logic [ADDR_W-1:0] best_gateway;
		logic [PORT_W-1:0] best_port;
	} item_t;

endpackage

FILE: design/ipv4_longest_prefix_route_lookup_core.sv
`timescale 1ns / 1ps
// longest-prefix route lookup over a chain of route cells
// s_* carries route writes (s_tuser = 1) and lookups (s_tuser = 0); m_* carries
// one result per lookup, writes give none
// every transaction walks the chain one cell per unstalled cycle, each cell holding one
// table slot, so writes and lookups keep their order without extra hazards
// throughput: one transaction per cycle while the output is not stalled
// from input acceptance to m_tvalid a lookup passes through the register of
// every chain cell followed by the output register
// reset clears every slot's active bit and empties the chain and output
// when the output is valid and m_tready is low the whole chain freezes and
// s_tready drops until the result is taken
// m_tuser is the found flag; with no match the result data is all zero
// only slots 0 to 15 can be written since the slot field is four bits
module ipv4_longest_prefix_route_lookup_core
	import lpm_pkg::*;
#(
	parameter int TABLE_SLOTS = 16
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   s_tvalid,
	output logic                   s_tready,
	// slot, slot_valid, route_prefix, route_mask, route_gateway, route_port,
	// lookup_address, zero pad
	input  logic [IN_TDATA_W-1:0]  s_tdata,
	// cmd
	input  logic                   s_tuser,
	output logic                   m_tvalid,
	input  logic                   m_tready,
	// matched_slot, out_port, next_hop_address, zero pad
	output logic [OUT_TDATA_W-1:0] m_tdata,
	// found
	output logic                   m_tuser
);

	item_t             chain [TABLE_SLOTS+1];
	item_t             tail;
	logic              adv;
	logic              out_valid_q;
	logic              found_q;
	logic [SLOT_W-1:0] slot_q;
	logic [PORT_W-1:0] port_q;
	logic [ADDR_W-1:0] hop_q;

	assign adv      = !out_valid_q || m_tready;
	assign s_tready = adv;

	always_comb begin
		chain[0]              = '0;
		chain[0].valid        = s_tvalid;
		chain[0].cmd          = cmd_t'(s_tuser);
		chain[0].slot         = s_tdata[3:0];
		chain[0].slot_valid   = s_tdata[4];
		chain[0].prefix       = s_tdata[36:5];
		chain[0].mask         = s_tdata[68:37];
		chain[0].gateway      = s_tdata[100:69];
		chain[0].port         = s_tdata[102:101];
		chain[0].addr         = s_tdata[134:103];
	end

	for (genvar i = 0; i < TABLE_SLOTS; i++) begin : g_cell
		lpm_cell #(
			.IDX(i)
		) u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.adv     (adv),
			.in_item (chain[i]),
			.out_item(chain[i+1])
		);
	end

	assign tail = chain[TABLE_SLOTS];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= tail.valid && (tail.cmd == CMD_LOOKUP);
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			found_q <= tail.hit;
			slot_q  <= tail.hit ? tail.best_slot : '0;
			port_q  <= tail.hit ? tail.best_port : '0;
			if (!tail.hit) begin
				hop_q <= '0;
			end else if (tail.best_gateway != '0) begin
				hop_q <= tail.best_gateway;
			end else begin
				hop_q <= tail.addr;
			end
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tuser  = found_q;
	assign m_tdata  = {2'b00, hop_q, port_q, slot_q};

endmodule

FILE: design/lpm_cell.sv
`timescale 1ns / 1ps
module lpm_cell
	import lpm_pkg::*;
#(
	parameter int IDX = 0
) (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  adv,
	input  item_t in_item,
	output item_t out_item
);

	logic              act_q;
	logic [ADDR_W-1:0] prefix_q;
	logic [ADDR_W-1:0] mask_q;
	logic [ADDR_W-1:0] gateway_q;
	logic [PORT_W-1:0] port_q;
	item_t             item_s1;
	item_t             nxt;
	logic              wr_hit;
	logic              match;
	logic              take;

	// only slots reachable by the slot field can be written
	assign wr_hit = in_item.valid && (in_item.cmd == CMD_WRITE) && (IDX < (1 << SLOT_W))
		&& (in_item.slot == SLOT_W'(IDX));

	assign match = act_q && ((in_item.addr & mask_q) == (prefix_q & mask_q));
	assign take  = in_item.valid && (in_item.cmd == CMD_LOOKUP) && match
		&& (!in_item.hit || (mask_q > in_item.best_mask));

	always_comb begin
		nxt = in_item;
		if (take) begin
			nxt.hit          = 1'b1;
			nxt.best_slot    = SLOT_W'(IDX);
			nxt.best_mask    = mask_q;
			nxt.best_gateway = gateway_q;
			nxt.best_port    = port_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			act_q <= 1'b0;
		end else if (adv && wr_hit) begin
			act_q <= in_item.slot_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && wr_hit) begin
			prefix_q  <= in_item.prefix;
			mask_q    <= in_item.mask;
			gateway_q <= in_item.gateway;
			port_q    <= in_item.port;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			item_s1.valid <= 1'b0;
		end else if (adv) begin
			item_s1 <= nxt;
		end
	end

	assign out_item = item_s1;

endmodule

FILE: design/lpm_chk.sv
`timescale 1ns / 1ps
module lpm_chk
	import lpm_pkg::*;
(
	input logic                   clk,
	input logic                   arst_n,
	input logic                   s_tvalid,
	input logic                   s_tready,
	input logic [IN_TDATA_W-1:0]  s_tdata,
	input logic                   s_tuser,
	input logic                   m_tvalid,
	input logic                   m_tready,
	input logic [OUT_TDATA_W-1:0] m_tdata,
	input logic                   m_tuser
);

	a_hold_valid: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid)
		else $error("result dropped while stalled");

	a_hold_data: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> $stable(m_tdata) && $stable(m_tuser))
		else $error("result changed while stalled");

	a_stall_back: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |-> !s_tready)
		else $error("input taken while output stalled");

	a_miss_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tuser |-> m_tdata == '0)
		else $error("miss result not zero");

	a_in_hold: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && !s_tready |=> s_tvalid && $stable(s_tdata) && $stable(s_tuser))
		else $error("input transaction changed while waiting");

endmodule

bind ipv4_longest_prefix_route_lookup_core lpm_chk u_lpm_chk (.*);
